// ===== design/wdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Wind direction package
// Shared widths, constants, types and the arctangent table for the CORDIC
// pipeline that turns wind components into a compass direction.
// ----------------------------------------------------------------------------
package wdfc_pkg;

   localparam int COMPONENT_WIDTH_DEF  = 16;
   localparam int ANGLE_ITERATIONS_DEF = 18;

   // Working vector: components are placed so that the magnitude sits near bit 59.
   localparam int DATA_WIDTH  = 64;
   localparam int SCALE_POINT = 60;

   // Angle accumulator in units of 2^-24 degree.
   localparam int FRAC_BITS     = 24;
   localparam int ACC_WIDTH     = 34;
   localparam int WRAP_WIDTH    = ACC_WIDTH - 1;
   localparam int CENTI_BITS    = 7;
   localparam int PRODUCT_WIDTH = WRAP_WIDTH + CENTI_BITS;
   localparam int DIR_WIDTH     = 16;
   localparam int TABLE_INDEX_WIDTH = 5;

   typedef logic signed [DATA_WIDTH-1:0] coord_type;
   typedef logic signed [ACC_WIDTH-1:0]  angle_type;

   localparam angle_type QUARTER_TURN = 34'sd1509949440;
   localparam angle_type FULL_TURN    = 34'sd6039797760;

   localparam logic [PRODUCT_WIDTH-1:0] CENTI_SCALE = 40'd100;
   localparam logic [PRODUCT_WIDTH-1:0] ROUND_HALF  = 40'd8388608;
   localparam logic [DIR_WIDTH-1:0]     DIR_FULL    = 16'd36000;

   // Flags that ride alongside each item through the pipeline.
   typedef struct packed {
      logic missing;
      logic calm;
      logic is_last;
   } side_type;

   // atan(2^-i) in degrees, scaled by 2^24 and rounded to nearest.
   function automatic angle_type atan_entry(input logic [TABLE_INDEX_WIDTH-1:0] idx);
      case (idx)
         5'd0:  atan_entry = 34'sd754974720;
         5'd1:  atan_entry = 34'sd445687602;
         5'd2:  atan_entry = 34'sd235489089;
         5'd3:  atan_entry = 34'sd119537938;
         5'd4:  atan_entry = 34'sd60000934;
         5'd5:  atan_entry = 34'sd30029717;
         5'd6:  atan_entry = 34'sd15018523;
         5'd7:  atan_entry = 34'sd7509720;
         5'd8:  atan_entry = 34'sd3754917;
         5'd9:  atan_entry = 34'sd1877466;
         5'd10: atan_entry = 34'sd938734;
         5'd11: atan_entry = 34'sd469367;
         5'd12: atan_entry = 34'sd234684;
         5'd13: atan_entry = 34'sd117342;
         5'd14: atan_entry = 34'sd58671;
         5'd15: atan_entry = 34'sd29335;
         5'd16: atan_entry = 34'sd14668;
         5'd17: atan_entry = 34'sd7334;
         5'd18: atan_entry = 34'sd3667;
         5'd19: atan_entry = 34'sd1833;
         5'd20: atan_entry = 34'sd917;
         5'd21: atan_entry = 34'sd458;
         5'd22: atan_entry = 34'sd229;
         5'd23: atan_entry = 34'sd115;
         5'd24: atan_entry = 34'sd57;
         5'd25: atan_entry = 34'sd29;
         5'd26: atan_entry = 34'sd14;
         5'd27: atan_entry = 34'sd7;
         5'd28: atan_entry = 34'sd4;
         5'd29: atan_entry = 34'sd2;
         5'd30: atan_entry = 34'sd1;
         default: atan_entry = 34'sd0;
      endcase
   endfunction

endpackage

// ===== design/wind_direction_from_components.sv =====
// ----------------------------------------------------------------------------
// Wind direction from wind components
// Streams (u, v) wind components and returns the meteorological direction,
// atan2(-u, -v), in centidegrees through a fully pipelined CORDIC.
//
//   Channel  Role    Handshake          Payload
//   req_     input   tvalid / tready    tdata {v_wind, u_wind},
//                                       tuser {v_missing, u_missing}, tlast
//   rsp_     output  tvalid / tready    tdata direction, tuser result_missing,
//                                       tlast last_out
//
// One item enters per cycle unless the output stalls; the pipeline has one
// input stage, one stage per CORDIC iteration and three output stages.
// Reset clears every stage valid bit; the pipeline is empty afterwards.
// The whole pipeline advances together whenever the output register is empty
// or its transfer completes, so a stall freezes every stage in place.
// ----------------------------------------------------------------------------
module wind_direction_from_components #(
   parameter int COMPONENT_WIDTH  = wdfc_pkg::COMPONENT_WIDTH_DEF,
   parameter int ANGLE_ITERATIONS = wdfc_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // [COMPONENT_WIDTH-1:0] u_wind, [2*COMPONENT_WIDTH-1:COMPONENT_WIDTH] v_wind,
   // zero padding above
   input  logic [((2*COMPONENT_WIDTH+7)/8)*8-1:0]     req_tdata,
   // [0] u_missing, [1] v_missing
   input  logic [1:0]                                 req_tuser,
   input  logic                                       req_tlast,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // [15:0] direction
   output logic [wdfc_pkg::DIR_WIDTH-1:0]             rsp_tdata,
   // [0] result_missing
   output logic                                       rsp_tuser,
   output logic                                       rsp_tlast
);
   import wdfc_pkg::*;

   logic      advance;

   logic      [ANGLE_ITERATIONS:0] stage_valid;
   coord_type stage_x     [0:ANGLE_ITERATIONS];
   coord_type stage_y     [0:ANGLE_ITERATIONS];
   angle_type stage_angle [0:ANGLE_ITERATIONS];
   side_type  stage_side  [0:ANGLE_ITERATIONS];

   // Every stage moves when the result register can take a new item.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   wdfc_prep #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .u_wind     (req_tdata[COMPONENT_WIDTH-1:0]),
      .v_wind     (req_tdata[2*COMPONENT_WIDTH-1:COMPONENT_WIDTH]),
      .u_missing  (req_tuser[0]),
      .v_missing  (req_tuser[1]),
      .last_point (req_tlast),
      .out_valid  (stage_valid[0]),
      .x_out      (stage_x[0]),
      .y_out      (stage_y[0]),
      .angle_out  (stage_angle[0]),
      .side_out   (stage_side[0])
   );

   for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_rotate
      wdfc_rotate #(
         .IDX (i)
      ) u_rotate (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .in_valid      (stage_valid[i]),
         .x_in_data     (stage_x[i]),
         .y_in_data     (stage_y[i]),
         .angle_in_data (stage_angle[i]),
         .side_in_data  (stage_side[i]),
         .out_valid     (stage_valid[i+1]),
         .x_out         (stage_x[i+1]),
         .y_out         (stage_y[i+1]),
         .angle_out     (stage_angle[i+1]),
         .side_out      (stage_side[i+1])
      );
   end

   wdfc_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (stage_valid[ANGLE_ITERATIONS]),
      .angle_in_data  (stage_angle[ANGLE_ITERATIONS]),
      .side_in_data   (stage_side[ANGLE_ITERATIONS]),
      .out_valid      (rsp_tvalid),
      .direction      (rsp_tdata),
      .result_missing (rsp_tuser),
      .last_out       (rsp_tlast)
   );

   // The final stage x and y are only needed inside the last rotation.
   logic unused_xy;
   assign unused_xy = ^{stage_x[ANGLE_ITERATIONS], stage_y[ANGLE_ITERATIONS]};

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= DIR_FULL))
      else $error("direction above full circle");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("missing result carries a nonzero direction");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && (stage_valid == '0)))
      else $error("pipeline not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid))
      else $error("stage valid bits moved during a stall");

endmodule

// ===== design/wdfc_prep.sv =====
// ----------------------------------------------------------------------------
// Wind direction input stage
// Negates and scales the components into the CORDIC vector (-v, -u), turns
// left-half-plane vectors by a quarter turn and flags calm and missing data.
// ----------------------------------------------------------------------------
module wdfc_prep #(
   parameter int COMPONENT_WIDTH = wdfc_pkg::COMPONENT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [COMPONENT_WIDTH-1:0] u_wind,
   input  logic signed [COMPONENT_WIDTH-1:0] v_wind,
   input  logic                              u_missing,
   input  logic                              v_missing,
   input  logic                              last_point,
   output logic                              out_valid,
   output wdfc_pkg::coord_type               x_out,
   output wdfc_pkg::coord_type               y_out,
   output wdfc_pkg::angle_type               angle_out,
   output wdfc_pkg::side_type                side_out
);
   import wdfc_pkg::*;

   localparam int PRE_SHIFT = SCALE_POINT - COMPONENT_WIDTH;

   coord_type u_scaled;
   coord_type v_scaled;
   logic      v_positive;
   logic      u_nonpositive;

   logic      valid_ff;
   coord_type x_ff, x_in;
   coord_type y_ff, y_in;
   angle_type angle_ff, angle_in;
   side_type  side_ff, side_in;

   always_comb begin
      u_scaled = {{(DATA_WIDTH-COMPONENT_WIDTH){u_wind[COMPONENT_WIDTH-1]}}, u_wind};
      v_scaled = {{(DATA_WIDTH-COMPONENT_WIDTH){v_wind[COMPONENT_WIDTH-1]}}, v_wind};
      u_scaled = u_scaled <<< PRE_SHIFT;
      v_scaled = v_scaled <<< PRE_SHIFT;

      v_positive    = !v_wind[COMPONENT_WIDTH-1] && (v_wind != '0);
      u_nonpositive = u_wind[COMPONENT_WIDTH-1] || (u_wind == '0);

      // The vector is (-v, -u); a positive v puts it in the left half plane.
      if (v_positive && u_nonpositive) begin
         x_in     = -u_scaled;
         y_in     = v_scaled;
         angle_in = QUARTER_TURN;
      end else if (v_positive) begin
         x_in     = u_scaled;
         y_in     = -v_scaled;
         angle_in = -QUARTER_TURN;
      end else begin
         x_in     = -v_scaled;
         y_in     = -u_scaled;
         angle_in = '0;
      end

      side_in.missing = u_missing || v_missing;
      side_in.calm    = (u_wind == '0) && (v_wind == '0);
      side_in.is_last = last_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         angle_ff <= angle_in;
         side_ff  <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign angle_out = angle_ff;
   assign side_out  = side_ff;

endmodule

// ===== design/wdfc_rotate.sv =====
// ----------------------------------------------------------------------------
// Wind direction CORDIC stage
// One vectoring micro-rotation: drives y toward zero and accumulates the
// matching arctangent into the angle.
// ----------------------------------------------------------------------------
module wdfc_rotate #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  wdfc_pkg::coord_type x_in_data,
   input  wdfc_pkg::coord_type y_in_data,
   input  wdfc_pkg::angle_type angle_in_data,
   input  wdfc_pkg::side_type  side_in_data,
   output logic                out_valid,
   output wdfc_pkg::coord_type x_out,
   output wdfc_pkg::coord_type y_out,
   output wdfc_pkg::angle_type angle_out,
   output wdfc_pkg::side_type  side_out
);
   import wdfc_pkg::*;

   localparam angle_type STEP_ANGLE = atan_entry(TABLE_INDEX_WIDTH'(IDX));

   coord_type x_shift;
   coord_type y_shift;

   logic      valid_ff;
   coord_type x_ff, x_in;
   coord_type y_ff, y_in;
   angle_type angle_ff, angle_in;
   side_type  side_ff;

   always_comb begin
      x_shift = x_in_data >>> IDX;
      y_shift = y_in_data >>> IDX;
      if (!y_in_data[DATA_WIDTH-1]) begin
         x_in     = x_in_data + y_shift;
         y_in     = y_in_data - x_shift;
         angle_in = angle_in_data + STEP_ANGLE;
      end else begin
         x_in     = x_in_data - y_shift;
         y_in     = y_in_data + x_shift;
         angle_in = angle_in_data - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         angle_ff <= angle_in;
         side_ff  <= side_in_data;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign angle_out = angle_ff;
   assign side_out  = side_ff;

endmodule

// ===== design/wdfc_scale.sv =====
// ----------------------------------------------------------------------------
// Wind direction output stages
// Wraps the angle into (0, 360] degrees, converts it to centidegrees with
// round-half-up, applies the calm and missing overrides and holds the result.
// ----------------------------------------------------------------------------
module wdfc_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  wdfc_pkg::angle_type             angle_in_data,
   input  wdfc_pkg::side_type              side_in_data,
   output logic                            out_valid,
   output logic [wdfc_pkg::DIR_WIDTH-1:0]  direction,
   output logic                            result_missing,
   output logic                            last_out
);
   import wdfc_pkg::*;

   angle_type                 wrap_sum;
   logic [DIR_WIDTH-1:0]      centi;

   logic                      wrap_valid_ff;
   logic [WRAP_WIDTH-1:0]     wrap_ff, wrap_in;
   side_type                  wrap_side_ff;

   logic                      prod_valid_ff;
   logic [PRODUCT_WIDTH-1:0]  prod_ff, prod_in;
   side_type                  prod_side_ff;

   logic                      out_valid_ff;
   logic [DIR_WIDTH-1:0]      dir_ff, dir_in;
   logic                      missing_ff;
   logic                      last_ff;

   always_comb begin
      // A non-positive angle gets a full turn; the result is then always positive.
      if (angle_in_data <= 0) begin
         wrap_sum = angle_in_data + FULL_TURN;
      end else begin
         wrap_sum = angle_in_data;
      end
      wrap_in = wrap_sum[WRAP_WIDTH-1:0];

      prod_in = {{CENTI_BITS{1'b0}}, wrap_ff} * CENTI_SCALE + ROUND_HALF;

      centi = prod_ff[FRAC_BITS +: DIR_WIDTH];
      if (prod_side_ff.missing || prod_side_ff.calm) begin
         dir_in = '0;
      end else if ((centi == '0) || (centi > DIR_FULL)) begin
         dir_in = DIR_FULL;
      end else begin
         dir_in = centi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         wrap_valid_ff <= in_valid;
         prod_valid_ff <= wrap_valid_ff;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wrap_ff      <= wrap_in;
         wrap_side_ff <= side_in_data;
         prod_ff      <= prod_in;
         prod_side_ff <= wrap_side_ff;
         dir_ff       <= dir_in;
         missing_ff   <= prod_side_ff.missing;
         last_ff      <= prod_side_ff.is_last;
      end
   end

   assign out_valid      = out_valid_ff;
   assign direction      = dir_ff;
   assign result_missing = missing_ff;
   assign last_out       = last_ff;

endmodule
